// ===== rtl/psu_pkg.sv =====
// Shared constants, types and helpers for the Potts Metropolis site update block.
`default_nettype none
package psu_pkg;

  // Grid geometry and random width.
  localparam int unsigned DIM_X     = 16;
  localparam int unsigned DIM_Y     = 16;
  localparam int unsigned DIM_Z     = 16;
  localparam int unsigned RAND_BITS = 16;

  localparam int unsigned SITES  = DIM_X * DIM_Y * DIM_Z;
  localparam int unsigned ADDR_W = $clog2(SITES);
  localparam int unsigned CX_W   = $clog2(DIM_X);
  localparam int unsigned CY_W   = $clog2(DIM_Y);
  localparam int unsigned CZ_W   = $clog2(DIM_Z);

  // Field widths.
  localparam int unsigned SPIN_W  = 4;
  localparam int unsigned RAND_W  = 16;
  localparam int unsigned SUM_W   = 16;
  localparam int unsigned BOND_W  = 14;
  localparam int unsigned DELTA_W = 4;
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned WIDE_C  = 7;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic [RAND_W-1:0] RAND_MASK =
    (RAND_BITS >= RAND_W) ? {RAND_W{1'b1}} : RAND_W'((64'd1 << RAND_BITS) - 64'd1);

  localparam logic [SPIN_W-1:0] SPIN_RESET = SPIN_W'(1);
  localparam logic [SUM_W-1:0]  SUM_RESET  = SUM_W'(SITES);

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_STATES = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_LAST   = 3'd6;
  localparam int unsigned NUM_THR = 6;
  localparam int unsigned CFG_DATA_W = 16;

  // Operation codes.
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_WRITE  = 1'b1;

  typedef struct packed {
    logic                we;
    logic [ADDR_W-1:0]   waddr;
    logic [SPIN_W-1:0]   wdata;
    logic [ADDR_W-1:0]   raddr;
  } psu_ram_req_t;

  // Reduce a raw coordinate into 0..dim-1 by repeated subtraction.
  function automatic logic [WIDE_C-1:0] psu_reduce(input logic [POS_W-1:0] v,
                                                   input int unsigned dim);
    logic [WIDE_C-1:0] t;
    t = WIDE_C'(v);
    for (int i = 0; i < 8; i++) begin
      if (t >= WIDE_C'(dim)) t = t - WIDE_C'(dim);
    end
    return t;
  endfunction

  function automatic logic [WIDE_C-1:0] psu_inc(input logic [WIDE_C-1:0] v,
                                                input int unsigned dim);
    return (v == WIDE_C'(dim - 1)) ? '0 : v + WIDE_C'(1);
  endfunction

  function automatic logic [WIDE_C-1:0] psu_dec(input logic [WIDE_C-1:0] v,
                                                input int unsigned dim);
    return (v == '0) ? WIDE_C'(dim - 1) : v - WIDE_C'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] psu_site(input logic [WIDE_C-1:0] x,
                                                 input logic [WIDE_C-1:0] y,
                                                 input logic [WIDE_C-1:0] z);
    logic [ADDR_W:0] a;
    a = (ADDR_W+1)'(x) + (ADDR_W+1)'(DIM_X) *
        ((ADDR_W+1)'(y) + (ADDR_W+1)'(DIM_Y) * (ADDR_W+1)'(z));
    return a[ADDR_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/potts_metropolis_site_update.sv =====
// Top level: Metropolis site update of a periodic 3D q-state Potts grid.
// Sequence: an input beat passes through the read/count steps, a decide
//   state and a commit state, then the result register.
// One item at a time: a beat is taken only after the last has committed;
//   the single grid read port serves the center site and six neighbors in turn.
// Reset: rst_ni resets control state and config registers, then a clearing
//   pass writes spin one to all 4096 sites, ready held low.
`default_nettype none
module potts_metropolis_site_update (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Input beat tdata, lowest bit up: op, pos_x, pos_y, pos_z, spin_value,
  // rand_value, zero fill.
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [psu_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // Result beat tdata, lowest bit up: spin_after, accepted, delta_unlike,
  // spin_total, unlike_bond_total, range_error.
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [psu_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
  // Configuration write port.
  input  wire logic                               cfg_we_i,
  input  wire logic [psu_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [psu_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import psu_pkg::*;

  // Sequencer states.
  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_COMMIT = 3'd4;

  localparam logic [2:0] STEP_LAST = 3'd7;

  logic [2:0] state_q, state_d;
  logic [2:0] step_q, step_d;
  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;

  // Config registers.
  logic [SPIN_W-1:0] num_states_q;
  logic [RAND_W-1:0] thr_q [NUM_THR];

  // Item registers.
  logic              op_q;
  logic [CX_W-1:0]   x_q;
  logic [CY_W-1:0]   y_q;
  logic [CZ_W-1:0]   z_q;
  logic [SPIN_W-1:0] sv_q;
  logic [RAND_W-1:0] rv_q;
  logic              err_q;
  logic [SPIN_W-1:0] old_q;
  logic [CNT_W-1:0]  cnt_new_q, cnt_old_q;
  logic              take_q;
  logic [DELTA_W-1:0] delta_q;

  // Running totals.
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [BOND_W-1:0] bonds_q, bonds_d;

  // Result register.
  logic              out_valid_q;
  logic [SPIN_W-1:0] out_spin_q;
  logic              out_acc_q;
  logic [DELTA_W-1:0] out_delta_q;
  logic [SUM_W-1:0]  out_sum_q;
  logic [BOND_W-1:0] out_bonds_q;
  logic              out_err_q;

  psu_ram_req_t      ram_req;
  logic [SPIN_W-1:0] ram_rdata;

  logic              in_fire, out_fire, commit;
  logic [WIDE_C-1:0] xr, yr, zr;
  logic [WIDE_C-1:0] cx, cy, cz;
  logic [ADDR_W-1:0] rd_addr;
  logic [DELTA_W-1:0] d_calc;
  logic [2:0]        thr_sel;
  logic              take_calc;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);

  // Commit when the result register is free or drains this cycle.
  assign commit = (state_q == ST_COMMIT) && (!out_valid_q || m_axis_tready);

  // Fold raw coordinates into the grid.
  assign xr = psu_reduce(s_axis_tdata[4:1], DIM_X);
  assign yr = psu_reduce(s_axis_tdata[8:5], DIM_Y);
  assign zr = psu_reduce(s_axis_tdata[12:9], DIM_Z);

  assign cx = WIDE_C'(x_q);
  assign cy = WIDE_C'(y_q);
  assign cz = WIDE_C'(z_q);

  // Read order: center, then x+, x-, y+, y-, z+, z-.
  always_comb begin
    case (step_q)
      3'd1:    rd_addr = psu_site(psu_inc(cx, DIM_X), cy, cz);
      3'd2:    rd_addr = psu_site(psu_dec(cx, DIM_X), cy, cz);
      3'd3:    rd_addr = psu_site(cx, psu_inc(cy, DIM_Y), cz);
      3'd4:    rd_addr = psu_site(cx, psu_dec(cy, DIM_Y), cz);
      3'd5:    rd_addr = psu_site(cx, cy, psu_inc(cz, DIM_Z));
      3'd6:    rd_addr = psu_site(cx, cy, psu_dec(cz, DIM_Z));
      default: rd_addr = psu_site(cx, cy, cz);
    endcase
  end

  always_comb begin
    ram_req       = '0;
    ram_req.raddr = rd_addr;
    if (state_q == ST_CLEAR) begin
      ram_req.we    = 1'b1;
      ram_req.waddr = clr_addr_q;
      ram_req.wdata = SPIN_RESET;
    end else begin
      ram_req.we    = commit && take_q;
      ram_req.waddr = psu_site(cx, cy, cz);
      ram_req.wdata = sv_q;
    end
  end

  psu_spin_grid u_grid (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  // Acceptance decision: energy rise d picks threshold d.
  assign d_calc  = DELTA_W'({1'b0, cnt_new_q}) - DELTA_W'({1'b0, cnt_old_q});
  assign thr_sel = d_calc[2:0] - 3'd1;
  always_comb begin
    take_calc = 1'b0;
    if (!err_q) begin
      if (op_q == OP_WRITE || d_calc[DELTA_W-1] || d_calc == '0) begin
        take_calc = 1'b1;
      end else begin
        take_calc = (rv_q < thr_q[thr_sel]);
      end
    end
  end

  assign sum_d   = sum_q + SUM_W'(sv_q) - SUM_W'(old_q);
  assign bonds_d = bonds_q + {{(BOND_W-DELTA_W){delta_q[DELTA_W-1]}}, delta_q};

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    clr_addr_d = clr_addr_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_addr_d = clr_addr_q + ADDR_W'(1);
        if (clr_addr_q == ADDR_W'(SITES - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        step_d = '0;
        if (in_fire) state_d = ST_READ;
      end
      ST_READ: begin
        step_d = step_q + 3'd1;
        if (step_q == STEP_LAST) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (commit) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      step_q     <= '0;
      clr_addr_q <= '0;
    end else begin
      state_q    <= state_d;
      step_q     <= step_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // Config writes; indexes past the last threshold are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_states_q <= SPIN_W'(3);
      for (int i = 0; i < NUM_THR; i++) thr_q[i] <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_NUM_STATES) begin
        num_states_q <= cfg_wdata_i[SPIN_W-1:0];
      end else if (cfg_idx_i <= CFG_THR_LAST) begin
        thr_q[cfg_idx_i - 3'd1] <= cfg_wdata_i[RAND_W-1:0];
      end
    end
  end

  // Capture the item, accumulate neighbor counts and register the decision.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q      <= s_axis_tdata[0];
      x_q       <= xr[CX_W-1:0];
      y_q       <= yr[CY_W-1:0];
      z_q       <= zr[CZ_W-1:0];
      sv_q      <= s_axis_tdata[16:13];
      rv_q      <= s_axis_tdata[32:17] & RAND_MASK;
      err_q     <= (s_axis_tdata[16:13] == '0) || (s_axis_tdata[16:13] > num_states_q);
      cnt_new_q <= '0;
      cnt_old_q <= '0;
    end else if (state_q == ST_READ) begin
      if (step_q == 3'd1) begin
        old_q <= ram_rdata;
      end else if (step_q != 3'd0) begin
        cnt_new_q <= cnt_new_q + CNT_W'(ram_rdata != sv_q);
        cnt_old_q <= cnt_old_q + CNT_W'(ram_rdata != old_q);
      end
    end
    if (state_q == ST_DECIDE) begin
      take_q  <= take_calc;
      delta_q <= err_q ? '0 : d_calc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= SUM_RESET;
      bonds_q <= '0;
    end else if (commit && take_q) begin
      sum_q   <= sum_d;
      bonds_q <= bonds_d;
    end
  end

  // Result register: hold until the downstream takes the beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_spin_q  <= take_q ? sv_q : old_q;
      out_acc_q   <= take_q;
      out_delta_q <= delta_q;
      out_sum_q   <= take_q ? sum_d : sum_q;
      out_bonds_q <= take_q ? bonds_d : bonds_q;
      out_err_q   <= err_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_err_q, out_bonds_q, out_sum_q, out_delta_q,
                          out_acc_q, out_spin_q};

`ifndef SYNTH
  // A spin out of range is never taken and reports no bond change.
  a_err_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_err_q) |-> (!out_acc_q && out_delta_q == '0))
    else $error("range error result shows a taken spin");

  // The grid is written only by the clearing pass or a commit.
  a_write_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req.we |-> (state_q == ST_CLEAR || state_q == ST_COMMIT))
    else $error("grid write outside clear or commit");

  // Neighbor counts stay within six.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECIDE) |-> (cnt_new_q <= CNT_W'(6) && cnt_old_q <= CNT_W'(6)))
    else $error("neighbor count above six");

  // A commit never overwrites a result that is still waiting.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready && state_q == ST_COMMIT) |=> (state_q == ST_COMMIT))
    else $error("commit left while the result register was full");
`endif

endmodule
`default_nettype wire

// ===== rtl/psu_spin_grid.sv =====
// Spin grid memory: one write port, one registered read port.
`default_nettype none
module psu_spin_grid (
  input  wire logic                         clk_i,
  input  wire psu_pkg::psu_ram_req_t        req_i,
  output logic [psu_pkg::SPIN_W-1:0]        rdata_o
);
  import psu_pkg::*;

  logic [SPIN_W-1:0] mem [SITES];
  logic [SPIN_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the Potts Metropolis site update block.
module tb_top;
  import psu_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned END_WAIT    = 24;
  localparam int unsigned CHUNK_ITEMS = 255;

  // One update or write request, as carried on the input stream.
  typedef struct {
    logic              op;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [POS_W-1:0]  z;
    logic [SPIN_W-1:0] spin;
    logic [RAND_W-1:0] rnd;
  } site_item_t;

  // One result beat, field by field.
  typedef struct {
    logic [SPIN_W-1:0]  spin_after;
    logic               accepted;
    logic [DELTA_W-1:0] delta;
    logic [SUM_W-1:0]   spin_total;
    logic [BOND_W-1:0]  bond_total;
    logic               range_error;
  } site_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Input stream, driven from the pending queue.
  logic                 in_valid = 1'b0;
  logic [IN_DATA_W-1:0] in_data = '0;
  site_item_t           in_item;
  int unsigned          in_gap = 0;

  // Result stream backpressure.
  logic                 out_ready = 1'b0;
  int unsigned          out_gap = 0;

  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic                  s_axis_tready;
  logic                  m_axis_tvalid;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  bit          idle_enable = 1'b1;
  int unsigned error_count = 0;
  int unsigned beat_count = 0;
  int unsigned cycle_count = 0;

  site_item_t   pending_items[$];
  site_result_t expected_results[$];

  // Shadow of the grid, the running totals and the register file.
  logic [SPIN_W-1:0] grid_model [SITES];
  logic [SUM_W-1:0]  sum_model;
  logic [BOND_W-1:0] bonds_model;
  logic [SPIN_W-1:0] q_model;
  logic [RAND_W-1:0] thr_model [1:NUM_THR];

  // Center of the small region that most random items hit, so that
  // neighboring sites interact and the count change spreads over -6..6.
  int unsigned cluster_x, cluster_y, cluster_z;

  potts_metropolis_site_update DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (in_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (in_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (out_ready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Grid predictor
  // ---------------------------------------------------------------------------

  function automatic int site_index(int x, int y, int z);
    return x + DIM_X * (y + DIM_Y * z);
  endfunction

  // Count the six neighbors (with wraparound) whose spin differs from s.
  // On an axis of size two both neighbors are one site and count twice.
  function automatic int unlike_neighbors(int x, int y, int z, logic [SPIN_W-1:0] s);
    int n = 0;
    if (grid_model[site_index((x + 1) % DIM_X, y, z)] != s) n++;
    if (grid_model[site_index((x + DIM_X - 1) % DIM_X, y, z)] != s) n++;
    if (grid_model[site_index(x, (y + 1) % DIM_Y, z)] != s) n++;
    if (grid_model[site_index(x, (y + DIM_Y - 1) % DIM_Y, z)] != s) n++;
    if (grid_model[site_index(x, y, (z + 1) % DIM_Z)] != s) n++;
    if (grid_model[site_index(x, y, (z + DIM_Z - 1) % DIM_Z)] != s) n++;
    return n;
  endfunction

  // Apply one accepted item to the shadow state and return its result.
  function automatic site_result_t metropolis_predict(site_item_t it);
    site_result_t      r;
    int                px, py, pz, idx, d;
    logic [SPIN_W-1:0] old_spin;
    logic              take;
    px = int'(it.x) % DIM_X;
    py = int'(it.y) % DIM_Y;
    pz = int'(it.z) % DIM_Z;
    idx = site_index(px, py, pz);
    old_spin = grid_model[idx];
    d = 0;
    take = 1'b0;
    r.range_error = (it.spin == '0) || (it.spin > q_model);
    if (!r.range_error) begin
      d = unlike_neighbors(px, py, pz, it.spin) - unlike_neighbors(px, py, pz, old_spin);
      if (it.op == OP_WRITE || d <= 0) begin
        take = 1'b1;
      end else if ((it.rnd & RAND_MASK) < thr_model[d]) begin
        take = 1'b1;
      end
      if (take) begin
        grid_model[idx] = it.spin;
        sum_model = SUM_W'(int'(sum_model) + int'(it.spin) - int'(old_spin));
        bonds_model = BOND_W'(int'(bonds_model) + d);
      end
    end
    r.spin_after = grid_model[idx];
    r.accepted = take;
    r.delta = DELTA_W'(d);
    r.spin_total = sum_model;
    r.bond_total = bonds_model;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: take items from the pending queue, with random idle bursts
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else if (!in_valid || s_axis_tready) begin
      if (in_gap != 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        in_item <= pending_items[0];
        in_data <= {7'b0, pending_items[0].rnd, pending_items[0].spin, pending_items[0].z,
                    pending_items[0].y, pending_items[0].x, pending_items[0].op};
        pending_items.pop_front();
        in_valid <= 1'b1;
        // Hold off after this beat now and then.
        if (idle_enable && $urandom_range(0, 7) == 0) in_gap <= $urandom_range(1, 17);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side backpressure: random stall bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      out_gap <= 0;
    end else if (idle_enable && out_gap != 0) begin
      out_gap <= out_gap - 1;
      out_ready <= 1'b0;
    end else if (idle_enable && $urandom_range(0, 11) == 0) begin
      out_gap <= $urandom_range(0, 16);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on each accepted input beat, check each result beat
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string field, longint got, longint want);
    error_count++;
    $display("[%0t] result beat %0d: %s got 0x%0h, want 0x%0h",
             $realtime, beat_count, field, got, want);
  endtask

  task automatic check_result(logic [OUT_DATA_W-1:0] raw);
    site_result_t want;
    if (expected_results.size() == 0) begin
      error_count++;
      $display("[%0t] result beat %0d arrived with nothing outstanding: 0x%0h",
               $realtime, beat_count, raw);
    end else begin
      want = expected_results.pop_front();
      if (raw[3:0] !== want.spin_after)
        report_mismatch("spin_after", raw[3:0], want.spin_after);
      if (raw[4] !== want.accepted)
        report_mismatch("accepted", raw[4], want.accepted);
      if (raw[8:5] !== want.delta)
        report_mismatch("delta_unlike", raw[8:5], want.delta);
      if (raw[24:9] !== want.spin_total)
        report_mismatch("spin_total", raw[24:9], want.spin_total);
      if (raw[38:25] !== want.bond_total)
        report_mismatch("unlike_bond_total", raw[38:25], want.bond_total);
      if (raw[39] !== want.range_error)
        report_mismatch("range_error", raw[39], want.range_error);
    end
    beat_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && out_ready) check_result(m_axis_tdata);
      if (in_valid && s_axis_tready) expected_results.push_back(metropolis_predict(in_item));
    end
  end

  // Watchdog: the slowest correct run, including the clearing pass, stays far below.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic push_item(logic op, int x, int y, int z, int spin, int rnd);
    site_item_t it;
    it.op = op;
    it.x = POS_W'(x);
    it.y = POS_W'(y);
    it.z = POS_W'(z);
    it.spin = SPIN_W'(spin);
    it.rnd = RAND_W'(rnd);
    pending_items.push_back(it);
  endtask

  // Wait until every item has gone in and every result has come back.
  task automatic drain();
    @(negedge clk_i);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Load q and all six thresholds; thr[d] is the threshold for a rise of d.
  task automatic set_config(int q, logic [NUM_THR:1][RAND_W-1:0] thr);
    write_reg(CFG_NUM_STATES, CFG_DATA_W'(q));
    q_model = SPIN_W'(q);
    for (int d = 1; d <= NUM_THR; d++) begin
      write_reg(CFG_NUM_STATES + CFG_IDX_W'(d), thr[d]);
      thr_model[d] = thr[d];
    end
  endtask

  // Random item: mostly proposals and writes of legal spins around the
  // cluster, some anywhere in the grid, a few with an illegal spin.
  task automatic push_random_item();
    int unsigned roll, x, y, z, spin;
    logic        op;
    roll = $urandom_range(0, 99);
    op = ($urandom_range(0, 99) < 25) ? OP_WRITE : OP_UPDATE;
    if ($urandom_range(0, 4) == 0) begin
      x = $urandom_range(0, 15);
      y = $urandom_range(0, 15);
      z = $urandom_range(0, 15);
    end else begin
      x = (cluster_x + $urandom_range(0, 3)) % 16;
      y = (cluster_y + $urandom_range(0, 3)) % 16;
      z = (cluster_z + $urandom_range(0, 3)) % 16;
    end
    if (roll < 5) begin
      spin = (q_model >= 15 || $urandom_range(0, 1) == 0) ? 0 : $urandom_range(q_model + 1, 15);
    end else begin
      spin = $urandom_range(1, q_model);
    end
    push_item(op, x, y, z, spin, $urandom_range(0, 65535));
  endtask

  task automatic run_random_chunk(int unsigned count);
    cluster_x = $urandom_range(0, 15);
    cluster_y = $urandom_range(0, 15);
    cluster_z = $urandom_range(0, 15);
    for (int unsigned i = 0; i < count; i++) push_random_item();
    drain();
  endtask

  initial begin
    logic [NUM_THR:1][RAND_W-1:0] thr;

    // Shadow state after reset: every site spin one, defaults in the registers.
    foreach (grid_model[i]) grid_model[i] = SPIN_RESET;
    sum_model = SUM_RESET;
    bonds_model = '0;
    q_model = SPIN_W'(3);
    for (int d = 1; d <= NUM_THR; d++) thr_model[d] = '0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed, reset configuration: q is three, every threshold zero.
    push_item(OP_UPDATE, 0, 0, 0, 1, 16'h0000);   // same spin, nothing changes
    push_item(OP_UPDATE, 0, 0, 0, 2, 16'hFFFF);   // rise of six, threshold zero
    push_item(OP_WRITE, 0, 0, 0, 2, 16'h0000);    // direct write, six new bonds
    push_item(OP_UPDATE, 1, 0, 0, 2, 16'h0000);   // rise of four, rejected
    push_item(OP_UPDATE, 0, 0, 0, 1, 16'h1234);   // drop of six, always taken
    push_item(OP_WRITE, 15, 15, 15, 3, 16'hFFFF); // far corner, neighbors wrap around
    push_item(OP_WRITE, 15, 15, 15, 0, 16'h0000); // spin zero rejected
    push_item(OP_UPDATE, 0, 15, 0, 4, 16'h0000);  // spin above q rejected
    push_item(OP_WRITE, 14, 15, 15, 3, 16'h0000);
    push_item(OP_UPDATE, 15, 15, 15, 1, 16'h8000);
    push_item(OP_WRITE, 15, 0, 0, 15, 16'h0000);  // spin fifteen above q
    drain();

    // Thresholds at full scale: only a random value of all ones fails.
    set_config(15, {NUM_THR{16'hFFFF}});
    push_item(OP_WRITE, 0, 0, 0, 15, 16'h0000);
    push_item(OP_UPDATE, 1, 0, 0, 7, 16'hFFFF);
    push_item(OP_UPDATE, 1, 0, 0, 7, 16'hFFFE);
    push_item(OP_WRITE, 8, 8, 8, 15, 16'h5555);
    push_item(OP_UPDATE, 0, 0, 0, 0, 16'hAAAA);
    drain();

    // Degenerate q of one: only spin one gets in.
    set_config(1, {NUM_THR{16'hFFFF}});
    push_item(OP_WRITE, 0, 0, 0, 1, 16'h0000);
    push_item(OP_UPDATE, 5, 5, 5, 2, 16'h0000);
    drain();

    // Degenerate q of zero: every item rejected.
    set_config(0, {NUM_THR{16'h0000}});
    push_item(OP_WRITE, 3, 3, 3, 1, 16'h0000);
    push_item(OP_UPDATE, 3, 3, 3, 0, 16'h0000);
    drain();

    // Random phases, each separated by a full drain and a new setting.
    for (int d = 1; d <= NUM_THR; d++) thr[d] = RAND_W'($urandom_range(0, 65535));
    set_config(2, thr);
    run_random_chunk(CHUNK_ITEMS);

    for (int d = 1; d <= NUM_THR; d++) thr[d] = RAND_W'($urandom_range(0, 65535));
    set_config(15, thr);
    run_random_chunk(CHUNK_ITEMS);

    for (int d = 1; d <= NUM_THR; d++) thr[d] = 16'hFFFF >> d;
    set_config(4, thr);
    run_random_chunk(CHUNK_ITEMS);

    set_config(3, {NUM_THR{16'h0000}});
    run_random_chunk(CHUNK_ITEMS);

    set_config($urandom_range(2, 15), {NUM_THR{16'hFFFF}});
    run_random_chunk(CHUNK_ITEMS);

    // Last part at full rate: no idling on either side.
    for (int d = 1; d <= NUM_THR; d++) thr[d] = RAND_W'($urandom_range(0, 65535));
    set_config(5, thr);
    idle_enable = 1'b0;
    run_random_chunk(CHUNK_ITEMS);

    // Let any stray result show up before closing.
    repeat (END_WAIT) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== potts_metropolis_site_update.f =====
rtl/psu_pkg.sv
rtl/psu_spin_grid.sv
rtl/potts_metropolis_site_update.sv
bench/tb_top.sv
